/* rtl/mcah_pkg.sv */
// ----------------------------------------------------------------------------
// mcah_pkg: shared types and constants for the assignment solver
// Widths, markers, register indexes, input kinds and sequencer states.
// ----------------------------------------------------------------------------
package mcah_pkg;

	localparam int MAX_N   = 16;
	localparam int IDX_W   = 4;
	localparam int PTR_W   = 5;
	localparam int DIM_W   = 5;
	localparam int COST_W  = 32;
	localparam int VAL_W   = 56;
	localparam int CELLS   = MAX_N * MAX_N;
	localparam int CADDR_W = 2 * IDX_W;

	localparam logic [PTR_W-1:0] NONE_MARK = 5'h1F;
	localparam logic [DIM_W-1:0] DIM_MAX   = 5'd16;

	localparam logic signed [VAL_W-1:0] INF_COST = 56'sd1099511627776;
	localparam logic signed [VAL_W:0]   SUM_MAX  = {2'b00, {(VAL_W-1){1'b1}}};
	localparam logic signed [VAL_W:0]   SUM_MIN  = {2'b11, {(VAL_W-1){1'b0}}};

	// configuration register indexes
	localparam logic REG_ROWS_USED = 1'b0;
	localparam logic REG_COLS_USED = 1'b1;

	// input item kinds
	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_SOLVE = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RMIN,
		S_CMIN,
		S_GREEDY,
		S_FINDS,
		S_DINIT,
		S_SEL,
		S_PICK,
		S_PREP,
		S_RELAX,
		S_POT,
		S_POTS,
		S_AUG,
		S_OUT
	} state_t;

endpackage

/* rtl/mcah_ram.sv */
// ----------------------------------------------------------------------------
// mcah_ram: generic single-port-write RAM with registered read
// One write and one read address per cycle; read data is registered and lands in the next cycle.
// ----------------------------------------------------------------------------
module mcah_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* rtl/min_cost_assignment_hungarian_unit.sv */
// ----------------------------------------------------------------------------
// min_cost_assignment_hungarian_unit: minimum-cost assignment solver
// Loads signed cost cells into a 16x16 store, then solves with the Hungarian
// method (greedy start, shortest augmenting paths, potential updates).
// ----------------------------------------------------------------------------
//
// Channel   | Signals                                | Handshake
// ----------+----------------------------------------+---------------------------
// input     | kind, row, col, cost                   | start high, busy low
// result    | out_row, assigned_col, total_cost,last | result_strobe, one cycle
// config    | wr_index, wr_data                      | wr_en, written at once
//
// A load transaction writes one cell and the block stays ready. A solve of
// size n = max(rows, cols) walks the matrix cell by cell, alternating address
// and data phases through the single cost store read port: the row minima,
// the column minima and a greedy pass. Each unmatched row is then found, its
// distances loaded and columns settled one at a time (select, pick, prep,
// relax); a potential sweep and the path flip follow. The pace is set by the
// shared compare/add unit and the store read port. Results leave one row at
// a time. Reset clears all written flags at once; no clearing pass. The
// receiver cannot stall.
//
module min_cost_assignment_hungarian_unit
	import mcah_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic                     kind,
	input  logic [IDX_W-1:0]         row,
	input  logic [IDX_W-1:0]         col,
	input  logic signed [COST_W-1:0] cost,
	input  logic                     wr_en,
	input  logic                     wr_index,
	input  logic [DIM_W-1:0]         wr_data,
	output logic                     result_strobe,
	output logic [IDX_W-1:0]         out_row,
	output logic [IDX_W-1:0]         assigned_col,
	output logic signed [VAL_W-1:0]  total_cost,
	output logic                     last
);

	state_t state_q, state_d;

	logic                    ph_q;
	logic [DIM_W-1:0]        rows_used_q, cols_used_q;
	logic [CELLS-1:0]        cell_wr_q;
	logic                    cwr_q, inb_q;

	logic [DIM_W-1:0]        n_q, nr_q, nc_q;
	logic [IDX_W-1:0]        a_q, b_q, s_q, cur_q, r_q;
	logic [PTR_W-1:0]        best_q;
	logic signed [VAL_W-1:0] bestd_q, m_q, base_q, total_q;

	logic signed [VAL_W-1:0] u_q [MAX_N];
	logic signed [VAL_W-1:0] v_q [MAX_N];
	logic signed [VAL_W-1:0] d_q [MAX_N];
	logic [PTR_W-1:0]        rm_q [MAX_N];
	logic [PTR_W-1:0]        cm_q [MAX_N];
	logic [PTR_W-1:0]        par_q [MAX_N];
	logic [MAX_N-1:0]        seen_q;

	logic                    res_q, last_q;
	logic [IDX_W-1:0]        orow_q, ocol_q;
	logic signed [VAL_W-1:0] otot_q;

	logic                    accept, is_load, is_solve, mem_state;
	logic [DIM_W-1:0]        nr_c, nc_c, n_c;
	logic                    a_last, b_last;
	logic [IDX_W-1:0]        out_c, rd_col;
	logic [CADDR_W-1:0]      rd_addr, wr_addr;
	logic [COST_W-1:0]       rdata;
	logic signed [VAL_W-1:0] mat_val, u_rd, v_rd, t_c, diff3, nd, mval, newm, w_c;
	logic signed [VAL_W:0]   sum_c;
	logic signed [VAL_W-1:0] tot_c;
	logic                    first, take;
	logic [PTR_W-1:0]        p_c, cmp_c;

	// ------------------------------------------------------------------------
	// cost store
	// ------------------------------------------------------------------------
	assign accept   = start && !busy;
	assign is_load  = accept && (kind == KIND_LOAD);
	assign is_solve = accept && (kind == KIND_SOLVE);
	assign wr_addr  = {row, col};

	mcah_ram #(
		.WIDTH(COST_W),
		.DEPTH(CELLS)
	) u_cost_ram (
		.clk  (clk),
		.we   (is_load),
		.waddr(wr_addr),
		.wdata(cost),
		.raddr(rd_addr),
		.rdata(rdata)
	);

	// ------------------------------------------------------------------------
	// shared datapath
	// ------------------------------------------------------------------------
	assign nr_c = (rows_used_q > DIM_MAX) ? DIM_MAX : rows_used_q;
	assign nc_c = (cols_used_q > DIM_MAX) ? DIM_MAX : cols_used_q;
	assign n_c  = (nr_c > nc_c) ? nr_c : nc_c;

	assign a_last = ({1'b0, a_q} == n_q - 5'd1);
	assign b_last = ({1'b0, b_q} == n_q - 5'd1);

	// output column: unmatched rows report column zero
	assign out_c   = (rm_q[a_q] < n_q) ? rm_q[a_q][IDX_W-1:0] : '0;
	assign rd_col  = (state_q == S_OUT) ? out_c : b_q;
	assign rd_addr = {a_q, rd_col};

	// matrix view of the cell fetched last cycle
	assign mat_val = cwr_q ? VAL_W'(signed'(rdata)) : (inb_q ? INF_COST : '0);

	assign u_rd  = u_q[a_q];
	assign v_rd  = v_q[b_q];
	assign t_c   = mat_val - u_rd;
	assign diff3 = t_c - v_rd;
	assign nd    = base_q + mat_val - v_rd;
	assign mval  = (state_q == S_RMIN) ? mat_val : t_c;
	assign first = (state_q == S_RMIN) ? (b_q == '0) : (a_q == '0);
	assign newm  = (first || (mval < m_q)) ? mval : m_q;
	assign take  = !seen_q[b_q] && ((best_q == NONE_MARK) || (d_q[b_q] < bestd_q));
	assign w_c   = d_q[b_q] - bestd_q;
	assign p_c   = par_q[cur_q];
	assign cmp_c = cm_q[p_c[IDX_W-1:0]];

	assign sum_c = {total_q[VAL_W-1], total_q} + {mat_val[VAL_W-1], mat_val};
	assign tot_c = (sum_c > SUM_MAX) ? SUM_MAX[VAL_W-1:0] :
		(sum_c < SUM_MIN) ? SUM_MIN[VAL_W-1:0] : sum_c[VAL_W-1:0];

	// ------------------------------------------------------------------------
	// sequencer: next state
	// ------------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (is_solve && (n_c != '0)) state_d = S_RMIN;
			end
			S_RMIN: begin
				if (ph_q && b_last && a_last) state_d = S_CMIN;
			end
			S_CMIN: begin
				if (ph_q && a_last && b_last) state_d = S_GREEDY;
			end
			S_GREEDY: begin
				if (ph_q && a_last && (b_last || ((cm_q[b_q] == NONE_MARK) && (diff3 == '0))))
					state_d = S_FINDS;
			end
			S_FINDS: begin
				if (rm_q[s_q] == NONE_MARK) state_d = S_DINIT;
				else if ({1'b0, s_q} == n_q - 5'd1) state_d = S_OUT;
			end
			S_DINIT: begin
				if (ph_q && b_last) state_d = S_SEL;
			end
			S_SEL: begin
				if (b_last) state_d = S_PICK;
			end
			S_PICK: begin
				if (best_q == NONE_MARK) state_d = S_OUT;
				else if (cm_q[best_q[IDX_W-1:0]] >= n_q) state_d = S_POT;
				else state_d = S_PREP;
			end
			S_PREP: begin
				state_d = S_RELAX;
			end
			S_RELAX: begin
				if (ph_q && b_last) state_d = S_SEL;
			end
			S_POT: begin
				if (b_last) state_d = S_POTS;
			end
			S_POTS: begin
				state_d = S_AUG;
			end
			S_AUG: begin
				if (p_c >= n_q) state_d = S_FINDS;
			end
			S_OUT: begin
				if (ph_q && a_last) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// ------------------------------------------------------------------------
	// sequencer: decoded outputs
	// ------------------------------------------------------------------------
	always_comb begin
		busy      = 1'b1;
		mem_state = 1'b0;
		case (state_q)
			S_IDLE: busy = 1'b0;
			S_RMIN, S_CMIN, S_GREEDY, S_DINIT, S_RELAX, S_OUT: mem_state = 1'b1;
			default: mem_state = 1'b0;
		endcase
	end

	// ------------------------------------------------------------------------
	// control registers
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ph_q        <= 1'b0;
			res_q       <= 1'b0;
			rows_used_q <= DIM_MAX;
			cols_used_q <= DIM_MAX;
			cell_wr_q   <= '0;
		end else begin
			state_q <= state_d;
			// alternate address and data cycles while walking the store
			ph_q    <= mem_state ? ~ph_q : 1'b0;
			res_q   <= (state_q == S_OUT) && ph_q;
			if (wr_en) begin
				case (wr_index)
					REG_ROWS_USED: rows_used_q <= wr_data;
					REG_COLS_USED: cols_used_q <= wr_data;
					default: ;
				endcase
			end
			if (is_load) cell_wr_q[wr_addr] <= 1'b1;
		end
	end

	// ------------------------------------------------------------------------
	// datapath registers
	// ------------------------------------------------------------------------
	always_ff @(posedge clk) begin
		cwr_q <= cell_wr_q[rd_addr];
		inb_q <= ({1'b0, a_q} < nr_q) && ({1'b0, rd_col} < nc_q);

		case (state_q)
			S_IDLE: begin
				if (is_solve) begin
					nr_q    <= nr_c;
					nc_q    <= nc_c;
					n_q     <= n_c;
					a_q     <= '0;
					b_q     <= '0;
					total_q <= '0;
					for (int k = 0; k < MAX_N; k++) begin
						rm_q[k] <= NONE_MARK;
						cm_q[k] <= NONE_MARK;
					end
				end
			end
			S_RMIN: begin
				if (ph_q) begin
					m_q <= newm;
					if (b_last) begin
						u_q[a_q] <= newm;
						b_q      <= '0;
						a_q      <= a_last ? '0 : a_q + 1'b1;
					end else begin
						b_q <= b_q + 1'b1;
					end
				end
			end
			S_CMIN: begin
				if (ph_q) begin
					m_q <= newm;
					if (a_last) begin
						v_q[b_q] <= newm;
						a_q      <= '0;
						b_q      <= b_last ? '0 : b_q + 1'b1;
					end else begin
						a_q <= a_q + 1'b1;
					end
				end
			end
			S_GREEDY: begin
				if (ph_q) begin
					if ((cm_q[b_q] == NONE_MARK) && (diff3 == '0)) begin
						rm_q[a_q] <= {1'b0, b_q};
						cm_q[b_q] <= {1'b0, a_q};
						a_q       <= a_q + 1'b1;
						b_q       <= '0;
					end else if (b_last) begin
						a_q <= a_q + 1'b1;
						b_q <= '0;
					end else begin
						b_q <= b_q + 1'b1;
					end
				end
				s_q <= '0;
			end
			S_FINDS: begin
				if (rm_q[s_q] == NONE_MARK) begin
					a_q <= s_q;
					b_q <= '0;
					seen_q <= '0;
					for (int k = 0; k < MAX_N; k++) par_q[k] <= NONE_MARK;
				end else if ({1'b0, s_q} == n_q - 5'd1) begin
					a_q <= '0;
				end else begin
					s_q <= s_q + 1'b1;
				end
			end
			S_DINIT: begin
				if (ph_q) begin
					d_q[b_q] <= diff3;
					b_q      <= b_last ? '0 : b_q + 1'b1;
					if (b_last) best_q <= NONE_MARK;
				end
			end
			S_SEL: begin
				if (take) begin
					best_q  <= {1'b0, b_q};
					bestd_q <= d_q[b_q];
				end
				b_q <= b_last ? '0 : b_q + 1'b1;
			end
			S_PICK: begin
				cur_q <= best_q[IDX_W-1:0];
				r_q   <= cm_q[best_q[IDX_W-1:0]][IDX_W-1:0];
				a_q   <= cm_q[best_q[IDX_W-1:0]][IDX_W-1:0];
				b_q   <= '0;
				if (best_q != NONE_MARK) seen_q[best_q[IDX_W-1:0]] <= 1'b1;
				else a_q <= '0;
			end
			S_PREP: begin
				base_q <= bestd_q - u_q[r_q];
			end
			S_RELAX: begin
				if (ph_q) begin
					if (!seen_q[b_q] && (d_q[b_q] > nd)) begin
						d_q[b_q]   <= nd;
						par_q[b_q] <= {1'b0, cur_q};
					end
					b_q <= b_last ? '0 : b_q + 1'b1;
					if (b_last) best_q <= NONE_MARK;
				end
			end
			S_POT: begin
				if ((b_q != cur_q) && seen_q[b_q] && (cm_q[b_q] < n_q)) begin
					v_q[b_q]                  <= v_rd + w_c;
					u_q[cm_q[b_q][IDX_W-1:0]] <= u_q[cm_q[b_q][IDX_W-1:0]] - w_c;
				end
				b_q <= b_last ? '0 : b_q + 1'b1;
				if (b_last) a_q <= s_q;
			end
			S_POTS: begin
				u_q[s_q] <= u_rd + bestd_q;
			end
			S_AUG: begin
				if (p_c < n_q) begin
					cm_q[cur_q] <= cmp_c;
					if (cmp_c < n_q) rm_q[cmp_c[IDX_W-1:0]] <= {1'b0, cur_q};
					cur_q <= p_c[IDX_W-1:0];
				end else begin
					cm_q[cur_q] <= {1'b0, s_q};
					rm_q[s_q]   <= {1'b0, cur_q};
					s_q         <= '0;
				end
			end
			S_OUT: begin
				if (ph_q) begin
					total_q <= tot_c;
					orow_q  <= a_q;
					ocol_q  <= out_c;
					last_q  <= a_last;
					otot_q  <= a_last ? tot_c : '0;
					a_q     <= a_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign result_strobe = res_q;
	assign out_row       = orow_q;
	assign assigned_col  = ocol_q;
	assign total_cost    = otot_q;
	assign last          = last_q;

`ifndef SYNTH
	// a result leaves only after the block was busy solving
	assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> $past(busy))
		else $error("result strobe without a solve in progress");

	// the final result closes the run
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && last) |=> !result_strobe)
		else $error("result after the final one of a run");

	// every column on an augmenting path has been settled
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_AUG) |-> seen_q[cur_q])
		else $error("augmenting through an unsettled column");

	// only the final result carries the total
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && !last) |-> (total_cost == '0))
		else $error("total reported before the final result");
`endif

endmodule

/* verif/tb_min_cost_assignment_hungarian_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_min_cost_assignment_hungarian_unit: self-checking bench for the solver
// Loads cost cells, sets the problem size and issues solves. A behavioural
// Hungarian solver inside the bench predicts every row result, and each
// strobed result is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_min_cost_assignment_hungarian_unit;
	import mcah_pkg::*;

	localparam int NONE_IDX  = 255;
	localparam int QUIET_MAX = 400000;
	localparam int ITEM_GOAL = 470;

	typedef struct {
		logic [IDX_W-1:0]        r;
		logic [IDX_W-1:0]        c;
		logic signed [VAL_W-1:0] tot;
		logic                    lst;
	} row_result_t;

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic                     kind;
	logic [IDX_W-1:0]         row;
	logic [IDX_W-1:0]         col;
	logic signed [COST_W-1:0] cost;
	logic                     wr_en;
	logic                     wr_index;
	logic [DIM_W-1:0]         wr_data;
	logic                     result_strobe;
	logic [IDX_W-1:0]         out_row;
	logic [IDX_W-1:0]         assigned_col;
	logic signed [VAL_W-1:0]  total_cost;
	logic                     last;

	min_cost_assignment_hungarian_unit uut (.*);

	// bench copy of the block's state
	longint      cell_cost [CELLS];
	bit          cell_set  [CELLS];
	int unsigned rows_reg, cols_reg;
	longint      mat [MAX_N][MAX_N];
	longint      pot_row [MAX_N], pot_col [MAX_N], path_dist [MAX_N];
	int          match_row [MAX_N], match_col [MAX_N], via_col [MAX_N];
	bit          seen [MAX_N];

	row_result_t pending_rows[$];
	int          errors, items_sent, quiet_cycles;
	bit          idling_on;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hungarian walk over the n x n problem; leaves the matching in match_row
	function automatic void hungarian_walk(int n, int nr, int nc);
		int     i, j, k, matched, s, cur, best, r, d;
		longint m, t, nd, w;
		matched = 0;
		cur = 0;
		for (i = 0; i < n; i++)
			for (j = 0; j < n; j++) begin
				if (cell_set[i*MAX_N+j]) mat[i][j] = cell_cost[i*MAX_N+j];
				else if (i < nr && j < nc) mat[i][j] = longint'(INF_COST);
				else mat[i][j] = 0;
			end
		for (i = 0; i < n; i++) begin
			m = mat[i][0];
			for (j = 1; j < n; j++) if (mat[i][j] < m) m = mat[i][j];
			pot_row[i] = m;
		end
		for (j = 0; j < n; j++) begin
			m = mat[0][j] - pot_row[0];
			for (i = 1; i < n; i++) begin
				t = mat[i][j] - pot_row[i];
				if (t < m) m = t;
			end
			pot_col[j] = m;
		end
		for (i = 0; i < MAX_N; i++) begin
			match_row[i] = NONE_IDX;
			match_col[i] = NONE_IDX;
		end
		// greedy start on exactly tight cells
		for (i = 0; i < n; i++)
			for (j = 0; j < n; j++)
				if (match_col[j] == NONE_IDX && mat[i][j] - pot_row[i] - pot_col[j] == 0) begin
					match_row[i] = j;
					match_col[j] = i;
					matched++;
					break;
				end
		for (; matched < n; matched++) begin
			s = 0;
			while (s < n && match_row[s] != NONE_IDX) s++;
			if (s >= n) break;
			for (k = 0; k < MAX_N; k++) begin
				via_col[k] = NONE_IDX;
				seen[k] = 1'b0;
			end
			for (k = 0; k < n; k++) path_dist[k] = mat[s][k] - pot_row[s] - pot_col[k];
			forever begin
				best = NONE_IDX;
				for (k = 0; k < n; k++)
					if (!seen[k] && (best == NONE_IDX || path_dist[k] < path_dist[best]))
						best = k;
				if (best == NONE_IDX) return;
				cur = best;
				seen[cur] = 1'b1;
				r = match_col[cur];
				if (r == NONE_IDX || r >= n) break;
				for (k = 0; k < n; k++)
					if (!seen[k]) begin
						nd = path_dist[cur] + mat[r][k] - pot_row[r] - pot_col[k];
						if (path_dist[k] > nd) begin
							path_dist[k] = nd;
							via_col[k] = cur;
						end
					end
			end
			for (k = 0; k < n; k++)
				if (k != cur && seen[k] && match_col[k] < n) begin
					w = path_dist[k] - path_dist[cur];
					pot_col[k] += w;
					pot_row[match_col[k]] -= w;
				end
			pot_row[s] += path_dist[cur];
			// flip the augmenting path
			while (via_col[cur] < n) begin
				d = via_col[cur];
				match_col[cur] = match_col[d];
				if (match_col[cur] < n) match_row[match_col[cur]] = cur;
				cur = d;
			end
			match_col[cur] = s;
			match_row[s] = cur;
		end
	endfunction

	// apply one accepted transaction to the bench state and queue its rows
	function automatic void predict_transaction(logic k, logic [3:0] r, logic [3:0] c,
			logic signed [31:0] v);
		int          nr, nc, n, i, j;
		longint      tot, x;
		row_result_t e;
		if (k == KIND_LOAD) begin
			cell_cost[{r, c}] = longint'(v);
			cell_set[{r, c}] = 1'b1;
			return;
		end
		nr = rows_reg > MAX_N ? MAX_N : rows_reg;
		nc = cols_reg > MAX_N ? MAX_N : cols_reg;
		n = nr > nc ? nr : nc;
		if (n == 0) return;
		hungarian_walk(n, nr, nc);
		tot = 0;
		for (i = 0; i < n; i++) begin
			j = match_row[i] < n ? match_row[i] : 0;
			x = mat[i][j];
			if (x > 0 && tot > longint'(SUM_MAX) - x) tot = longint'(SUM_MAX);
			else if (x < 0 && tot < longint'(SUM_MIN) - x) tot = longint'(SUM_MIN);
			else tot += x;
			e.r = IDX_W'(i);
			e.c = IDX_W'(j);
			e.tot = (i == n - 1) ? tot[VAL_W-1:0] : '0;
			e.lst = (i == n - 1);
			pending_rows.push_back(e);
		end
	endfunction

	// check every strobed row against the oldest prediction
	always @(posedge clk) begin
		row_result_t e;
		if (arst_n && result_strobe) begin
			if (pending_rows.size() == 0) begin
				$display("%0t: unexpected result row=%0d col=%0d", $time, out_row, assigned_col);
				errors++;
			end else begin
				e = pending_rows.pop_front();
				if (out_row !== e.r) begin
					$display("%0t: out_row exp %0d got %0d", $time, e.r, out_row);
					errors++;
				end
				if (assigned_col !== e.c) begin
					$display("%0t: assigned_col exp %0d got %0d (row %0d)", $time, e.c,
						assigned_col, e.r);
					errors++;
				end
				if (total_cost !== e.tot) begin
					$display("%0t: total_cost exp %0d got %0d", $time, e.tot, total_cost);
					errors++;
				end
				if (last !== e.lst) begin
					$display("%0t: last exp %0b got %0b", $time, e.lst, last);
					errors++;
				end
			end
		end
	end

	// watchdog: count cycles in which no transaction moves on either side
	always @(posedge clk) begin
		if (!arst_n || result_strobe || (start && !busy)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_MAX) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// send one input transaction, with an optional idle burst in front
	task automatic send_item(logic k, logic [3:0] r, logic [3:0] c, logic signed [31:0] v);
		bit done;
		done = 1'b0;
		if (idling_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		start <= 1'b1;
		kind  <= k;
		row   <= r;
		col   <= c;
		cost  <= v;
		while (!done) begin
			@(negedge clk);
			done = !busy;
			@(posedge clk);
		end
		predict_transaction(k, r, c, v);
		items_sent++;
	endtask

	// hold until all rows are in and the block has gone quiet
	task automatic drain();
		bit quiet;
		start <= 1'b0;
		quiet = 1'b0;
		while (!quiet) begin
			@(negedge clk);
			quiet = pending_rows.size() == 0 && !busy;
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, int unsigned val);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val[DIM_W-1:0];
		@(posedge clk);
		wr_en <= 1'b0;
		if (idx == REG_ROWS_USED) rows_reg = val & 5'h1F;
		else cols_reg = val & 5'h1F;
	endtask

	task automatic set_size(int unsigned nr, int unsigned nc);
		drain();
		write_reg(REG_ROWS_USED, nr);
		write_reg(REG_COLS_USED, nc);
	endtask

	function automatic logic signed [31:0] pick_cost();
		case ($urandom_range(0, 4))
			0: return $urandom_range(0, 3);
			1: return $signed($urandom_range(0, 10)) - 5;
			2: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
			default: return $urandom;
		endcase
	endfunction

	// reset sizes with nothing loaded: every cell reads as the sentinel
	task automatic test_untouched_store();
		send_item(KIND_SOLVE, 4'd0, 4'd0, 32'sd0);
	endtask

	// field extremes, rectangular padding and out-of-range sizes
	task automatic test_directed();
		set_size(3, 3);
		send_item(KIND_LOAD, 4'd0, 4'd0, 32'sh7FFF_FFFF);
		send_item(KIND_LOAD, 4'd0, 4'd1, 32'sh8000_0000);
		send_item(KIND_LOAD, 4'd1, 4'd1, 32'sh8000_0000);
		send_item(KIND_LOAD, 4'd1, 4'd2, -32'sd1);
		send_item(KIND_LOAD, 4'd2, 4'd0, 32'sd0);
		send_item(KIND_LOAD, 4'd15, 4'd15, 32'sh5555_AAAA);
		send_item(KIND_LOAD, 4'd15, 4'd0, 32'shAAAA_5555);
		send_item(KIND_SOLVE, 4'd15, 4'd15, 32'sh7FFF_FFFF);
		// wide problem: padding rows read as zero
		set_size(2, 5);
		send_item(KIND_SOLVE, 4'd0, 4'd0, 32'sd0);
		// tall problem
		set_size(6, 1);
		send_item(KIND_SOLVE, 4'd0, 4'd0, 32'sd0);
		// oversized registers act as the full store
		set_size(31, 17);
		send_item(KIND_SOLVE, 4'd0, 4'd0, 32'sd0);
		// empty problem: no rows come back
		set_size(0, 0);
		send_item(KIND_SOLVE, 4'd0, 4'd0, 32'sd0);
		set_size(1, 16);
		send_item(KIND_SOLVE, 4'd0, 4'd0, 32'sd0);
	endtask

	// random problems: a few loads in the active region, noise, then one or two solves
	task automatic test_random_problems();
		int unsigned nr, nc, loads, i;
		while (items_sent < ITEM_GOAL) begin
			if (items_sent > ITEM_GOAL - 70) idling_on = 1'b0;
			case ($urandom_range(0, 19))
				0:       begin nr = $urandom_range(0, 31); nc = $urandom_range(0, 31); end
				1, 2:    begin nr = $urandom_range(1, 16); nc = $urandom_range(1, 16); end
				default: begin nr = $urandom_range(1, 5);  nc = $urandom_range(1, 5);  end
			endcase
			set_size(nr, nc);
			loads = $urandom_range(0, 24);
			for (i = 0; i < loads; i++) begin
				if ($urandom_range(0, 7) == 0)
					send_item(KIND_LOAD, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
						pick_cost());
				else
					send_item(KIND_LOAD,
						4'($urandom_range(0, nr > 0 && nr <= 16 ? nr - 1 : 15)),
						4'($urandom_range(0, nc > 0 && nc <= 16 ? nc - 1 : 15)), pick_cost());
			end
			send_item(KIND_SOLVE, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), $urandom);
			if ($urandom_range(0, 2) == 0)
				send_item(KIND_SOLVE, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
					$urandom);
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		start     = 1'b0;
		kind      = KIND_LOAD;
		row       = '0;
		col       = '0;
		cost      = '0;
		wr_en     = 1'b0;
		wr_index  = REG_ROWS_USED;
		wr_data   = '0;
		rows_reg  = 16;
		cols_reg  = 16;
		errors    = 0;
		items_sent = 0;
		idling_on = 1'b1;
		foreach (cell_set[i]) begin
			cell_set[i] = 1'b0;
			cell_cost[i] = 0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_untouched_store();
		test_directed();
		test_random_problems();

		drain();
		repeat (20) @(posedge clk);
		if (errors == 0 && pending_rows.size() == 0) $display("TEST PASSED");
		else $display("TEST FAILED");
		$finish;
	end

endmodule
